@@ hw/rtl/lfr_pkg.sv @@
`default_nettype none
package lfr_pkg;
    localparam int NUM_FRAMES = 64;
    localparam int FRAME_W = $clog2(NUM_FRAMES);
    localparam int COUNT_W = $clog2(NUM_FRAMES + 1);

    localparam logic [1:0] OP_VICTIM = 2'd0;
    localparam logic [1:0] OP_PIN    = 2'd1;
    localparam logic [1:0] OP_UNPIN  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;
endpackage
`default_nettype wire

@@ hw/rtl/lfr_ctrl.sv @@
`default_nettype none
module lfr_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    output lfr_pkg::cmd_t    cmd
);
    import lfr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_stall    = 1'b1;
        out_valid   = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

@@ hw/rtl/lfr_datapath.sv @@
`default_nettype none
module lfr_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lfr_pkg::cmd_t                 cmd,
    input  wire logic [1:0]                    op,
    input  wire logic [lfr_pkg::FRAME_W-1:0]   frame,
    output logic                               found,
    output logic [lfr_pkg::FRAME_W-1:0]        victim_frame,
    output logic [lfr_pkg::COUNT_W-1:0]        tracked_count
);
    import lfr_pkg::*;

    logic [FRAME_W-1:0] next_mem [NUM_FRAMES];
    logic [FRAME_W-1:0] prev_mem [NUM_FRAMES];

    logic [NUM_FRAMES-1:0] tracked_reg;
    logic [NUM_FRAMES-1:0] tracked_next;
    logic [COUNT_W-1:0]    len_reg;
    logic [COUNT_W-1:0]    len_next;
    logic [FRAME_W-1:0]    head_reg;
    logic [FRAME_W-1:0]    head_next;
    logic [FRAME_W-1:0]    tail_reg;
    logic [FRAME_W-1:0]    tail_next;
    logic [1:0]            op_reg;
    logic [FRAME_W-1:0]    frame_reg;
    logic [FRAME_W-1:0]    rd_next_reg;
    logic [FRAME_W-1:0]    rd_prev_reg;
    logic                  found_reg;
    logic                  found_next;
    logic [FRAME_W-1:0]    victim_reg;
    logic [FRAME_W-1:0]    victim_next;

    logic                  nwe;
    logic [FRAME_W-1:0]    nwa;
    logic [FRAME_W-1:0]    nwd;
    logic                  pwe;
    logic [FRAME_W-1:0]    pwa;
    logic [FRAME_W-1:0]    pwd;
    logic [FRAME_W-1:0]    rd_addr;

    assign rd_addr = (op == OP_VICTIM) ? head_reg : frame;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= op;
            frame_reg   <= frame;
            rd_next_reg <= next_mem[rd_addr];
            rd_prev_reg <= prev_mem[rd_addr];
        end
        if (nwe)
        begin
            next_mem[nwa] <= nwd;
        end
        if (pwe)
        begin
            prev_mem[pwa] <= pwd;
        end
        if (cmd.execute)
        begin
            found_reg  <= found_next;
            victim_reg <= victim_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracked_reg <= '0;
            len_reg     <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
        end
        else
        begin
            tracked_reg <= tracked_next;
            len_reg     <= len_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
        end
    end

    always_comb
    begin
        tracked_next = tracked_reg;
        len_next     = len_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        found_next   = 1'b0;
        victim_next  = '0;
        nwe = 1'b0;
        nwa = tail_reg;
        nwd = frame_reg;
        pwe = 1'b0;
        pwa = frame_reg;
        pwd = tail_reg;
        if (cmd.execute)
        begin
            case (op_reg)
                OP_VICTIM:
                begin
                    if (len_reg != '0)
                    begin
                        found_next             = 1'b1;
                        victim_next            = head_reg;
                        tracked_next[head_reg] = 1'b0;
                        head_next              = rd_next_reg;
                        len_next               = len_reg - 1'b1;
                    end
                end
                OP_PIN:
                begin
                    if (tracked_reg[frame_reg])
                    begin
                        tracked_next[frame_reg] = 1'b0;
                        len_next                = len_reg - 1'b1;
                        if (frame_reg == head_reg)
                        begin
                            head_next = rd_next_reg;
                        end
                        else
                        begin
                            nwe = 1'b1;
                            nwa = rd_prev_reg;
                            nwd = rd_next_reg;
                        end
                        if (frame_reg == tail_reg)
                        begin
                            tail_next = rd_prev_reg;
                        end
                        else
                        begin
                            pwe = 1'b1;
                            pwa = rd_next_reg;
                            pwd = rd_prev_reg;
                        end
                    end
                end
                OP_UNPIN:
                begin
                    if (!tracked_reg[frame_reg] && len_reg < COUNT_W'(NUM_FRAMES))
                    begin
                        tracked_next[frame_reg] = 1'b1;
                        len_next                = len_reg + 1'b1;
                        tail_next               = frame_reg;
                        pwe                     = 1'b1;
                        if (len_reg == '0)
                        begin
                            head_next = frame_reg;
                        end
                        else
                        begin
                            nwe = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign found         = found_reg;
    assign victim_frame  = victim_reg;
    assign tracked_count = len_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= COUNT_W'(NUM_FRAMES))
        else $error("list length beyond frame count");

    a_len_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tracked_reg) == int'(len_reg))
        else $error("list length differs from membership map");

    a_head_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg != '0 |-> tracked_reg[head_reg] && tracked_reg[tail_reg])
        else $error("head or tail frame not tracked");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.execute |=> $stable(len_reg) && $stable(tracked_reg))
        else $error("list changed outside execute");
endmodule
`default_nettype wire

@@ hw/rtl/lru_frame_replacer_unit.sv @@
`default_nettype none
// lru frame replacer: ordered list of evictable frames, least recent first
// input channel in_valid / in_stall carries op and frame; one beat per request
// op victim removes and returns the oldest frame, pin removes a frame,
// unpin appends an untracked frame at the recent end
// output channel out_valid / out_stall returns found, victim_frame and
// tracked_count for every request, exactly one beat each
// the list is a doubly linked list in two 64-entry memories indexed by frame,
// with head, tail, length and a membership bit per frame in flip-flops
// the request beat is captured together with the memory read, the list is
// updated in the execute state, then out_valid rises in the output state
// one request is handled at a time: the memory read, the list update and
// the output beat all finish before the next request beat is taken
// a stalled result holds unchanged; no new request is taken until it leaves
// reset clears the membership map and length at once; no clearing pass
module lru_frame_replacer_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    op,
    input  wire logic [lfr_pkg::FRAME_W-1:0]   frame,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               found,
    output logic [lfr_pkg::FRAME_W-1:0]        victim_frame,
    output logic [lfr_pkg::COUNT_W-1:0]        tracked_count
);
    import lfr_pkg::*;

    cmd_t cmd;

    lfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    lfr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .op            (op),
        .frame         (frame),
        .found         (found),
        .victim_frame  (victim_frame),
        .tracked_count (tracked_count)
    );
endmodule
`default_nettype wire

@@ bench/lru_frame_replacer_checker.sv @@
`timescale 1ns / 1ps
module lru_frame_replacer_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        in_stall,
    input  wire logic [1:0]                  op,
    input  wire logic [lfr_pkg::FRAME_W-1:0] frame,
    input  wire logic                        out_valid,
    input  wire logic                        out_stall,
    input  wire logic                        found,
    input  wire logic [lfr_pkg::FRAME_W-1:0] victim_frame,
    input  wire logic [lfr_pkg::COUNT_W-1:0] tracked_count,
    output int                               fail_count,
    output int                               pending
);
    import lfr_pkg::*;

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] victim;
        logic [COUNT_W-1:0] count;
    } evict_result_t;

    logic [FRAME_W-1:0] order_list[$];
    logic               member[NUM_FRAMES];
    evict_result_t      expected_results[$];

    function automatic evict_result_t apply_request(logic [1:0] code, logic [FRAME_W-1:0] f);
        evict_result_t r;
        r = '0;
        if (code == OP_VICTIM) begin
            if (order_list.size() > 0) begin
                r.victim = order_list.pop_front();
                r.found = 1'b1;
                member[r.victim] = 1'b0;
            end
        end else if (code == OP_PIN) begin
            if (member[f]) begin
                foreach (order_list[i])
                begin
                    if (order_list[i] == f)
                    begin
                        order_list.delete(i);
                        break;
                    end
                end
                member[f] = 1'b0;
            end
        end else if (code == OP_UNPIN) begin
            if (!member[f] && order_list.size() < NUM_FRAMES)
            begin
                order_list.push_back(f);
                member[f] = 1'b1;
            end
        end
        r.count = COUNT_W'(order_list.size());
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        evict_result_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            order_list.delete();
            expected_results.delete();
            foreach (member[i]) member[i] = 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(apply_request(op, frame));
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected result: expected none, actual %b %0d %0d",
                             $time, found, victim_frame, tracked_count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (found !== want.found)
                    begin
                        fail_count++;
                        $display("%0t found: expected %b, actual %b", $time, want.found, found);
                    end
                    if (victim_frame !== want.victim)
                    begin
                        fail_count++;
                        $display("%0t victim_frame: expected %0d, actual %0d",
                                 $time, want.victim, victim_frame);
                    end
                    if (tracked_count !== want.count)
                    begin
                        fail_count++;
                        $display("%0t tracked_count: expected %0d, actual %0d",
                                 $time, want.count, tracked_count);
                    end
                end
            end
        end
    end
endmodule

@@ bench/lru_frame_replacer_unit_test.sv @@
`timescale 1ns / 1ps
module lru_frame_replacer_unit_test;
    import lfr_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         op = OP_VICTIM;
    logic [FRAME_W-1:0] frame = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               found;
    logic [FRAME_W-1:0] victim_frame;
    logic [COUNT_W-1:0] tracked_count;
    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;
    logic               stall_quiet = 1'b0;

    always #5 clk = ~clk;

    lru_frame_replacer_unit dut (.*);

    lru_frame_replacer_checker checker_inst (.*);

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_quiet)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 29) == 0)
            out_stall <= 1'b1;
        else if (out_stall && $urandom_range(0, 3) != 0)
            out_stall <= 1'b1;
        else
            out_stall <= 1'b0;
    end

    task automatic send_request(logic [1:0] code, logic [FRAME_W-1:0] f);
        int gap;
        gap = gap_length();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= code;
        frame <= f;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        int n;
        int r;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_request(OP_VICTIM, 6'd63);
        send_request(OP_PIN, 6'd5);
        send_request(OP_UNPIN, 6'd0);
        send_request(OP_UNPIN, 6'd63);
        send_request(OP_UNPIN, 6'd21);
        send_request(OP_UNPIN, 6'd0);
        send_request(OP_PIN, 6'd63);
        send_request(OP_PIN, 6'd63);
        send_request(2'd3, 6'd42);
        send_request(OP_VICTIM, 6'd0);
        send_request(OP_VICTIM, 6'd0);
        send_request(OP_VICTIM, 6'd0);
        wait_drained();
        stall_quiet <= 1'b1;
        for (n = 0; n < 64; n++)
            send_request(OP_UNPIN, FRAME_W'(63 - n));
        send_request(OP_UNPIN, 6'd7);
        send_request(OP_PIN, 6'd40);
        send_request(OP_UNPIN, 6'd40);
        stall_quiet <= 1'b0;
        wait_drained();
        for (n = 0; n < 320; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_request(OP_UNPIN, FRAME_W'($urandom_range(0, 15 + 48 * (n / 160))));
            else if (r < 65)
                send_request(OP_PIN, FRAME_W'($urandom_range(0, 63)));
            else if (r < 95)
                send_request(OP_VICTIM, FRAME_W'($urandom));
            else
                send_request(2'd3, FRAME_W'($urandom));
            if (n % 100 == 50)
                wait_drained();
        end
        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
